// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted string unescaper package
// Shared item and result types, character codes and error codes.
// ----------------------------------------------------------------------------
package qsu_pkg;

	// Character codes used by the escape decode.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// Control bytes produced by escapes.
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// Error codes of a result word.
	localparam logic [1:0] ERR_OK          = 2'd0;
	localparam logic [1:0] ERR_DQUOTE      = 2'd1;
	localparam logic [1:0] ERR_SQUOTE      = 2'd2;
	localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

	// One input word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} qsu_item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_string;
		logic [1:0] error_code;
	} qsu_result_t;

endpackage

// ===== rtl/quoted_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// Quoted string unescaper
// Decodes backslash escapes in a quoted string, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one raw byte per word: s_tdata is the byte,
//   s_tuser flags the opening quote and s_tlast flags the closing byte.
//   The master channel gives at most one result word per input word:
//   m_tdata is the decoded byte, m_tuser carries byte_valid and the error
//   code, and m_tlast marks the end of a string.
//   A word passes the input register, then the result register. Throughput
//   is one byte per cycle while the receiver does not stall, set by the single
//   decode stage between the two registers. Opening quotes that do not end
//   the string, escape-opening backslashes and bytes skipped after an error
//   give no result word. Reset clears the quote character and the escape and
//   failure flags, and empties both registers. When the receiver stalls, the
//   result register holds its word, one more input word is still taken into
//   the input register, and s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module quoted_string_unescaper
	import qsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [0:0] s_tuser,   // [0] first_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] error_code
	output logic       m_tlast    // end_of_string
);

	qsu_item_t   item_s1;
	logic        valid_s1;
	logic        out_free;
	logic        fire;
	logic        has_result;
	qsu_result_t result;
	qsu_result_t result_s2;
	logic        valid_s2;

	// Handshake between the two stages.
	assign out_free = !valid_s2 || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{data_byte: s_tdata, first_byte: s_tuser[0],
				last_byte: s_tlast};
		end
	end

	qsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.out_byte;
	assign m_tuser  = {result_s2.error_code, result_s2.byte_valid};
	assign m_tlast  = result_s2.end_of_string;

endmodule

// ===== rtl/qsu_decode.sv =====
// ----------------------------------------------------------------------------
// Quoted string unescaper decode stage
// Holds the per-string state and decodes one registered input word into at
// most one result word.
// ----------------------------------------------------------------------------
module qsu_decode
	import qsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  qsu_item_t   item,
	output logic        has_result,
	output qsu_result_t result
);

	logic [7:0] quote_char_q;
	logic       escape_pending_q;
	logic       string_failed_q;

	logic [7:0] quote_char_d;
	logic       escape_pending_d;
	logic       string_failed_d;

	// Decode of one word against the current state.
	always_comb begin
		quote_char_d     = quote_char_q;
		escape_pending_d = escape_pending_q;
		string_failed_d  = string_failed_q;
		has_result       = 1'b0;
		result           = '{out_byte: 8'h00, byte_valid: 1'b0,
			end_of_string: 1'b0, error_code: ERR_OK};

		priority if (item.first_byte) begin
			// Opening quote restarts the string; a one-byte string ends at once.
			quote_char_d     = item.data_byte;
			escape_pending_d = 1'b0;
			string_failed_d  = 1'b0;
			if (item.last_byte) begin
				has_result           = 1'b1;
				result.end_of_string = 1'b1;
			end
		end else if (item.last_byte) begin
			// Closing byte is dropped; any pending escape or failure is cleared.
			escape_pending_d     = 1'b0;
			string_failed_d      = 1'b0;
			has_result           = 1'b1;
			result.end_of_string = 1'b1;
		end else if (string_failed_q) begin
			// Skip the rest of a failed string.
		end else if (!escape_pending_q) begin
			if (item.data_byte == CH_BSLASH) begin
				escape_pending_d = 1'b1;
			end else begin
				has_result        = 1'b1;
				result.out_byte   = item.data_byte;
				result.byte_valid = 1'b1;
			end
		end else begin
			// Second byte of an escape sequence.
			escape_pending_d  = 1'b0;
			has_result        = 1'b1;
			result.byte_valid = 1'b1;
			unique case (item.data_byte)
				CH_LOW_B:  result.out_byte = CTL_BS;
				CH_LOW_F:  result.out_byte = CTL_FF;
				CH_LOW_N:  result.out_byte = CTL_LF;
				CH_LOW_R:  result.out_byte = CTL_CR;
				CH_LOW_T:  result.out_byte = CTL_HT;
				CH_SPACE:  result.out_byte = CH_BSLASH;
				CH_BSLASH: result.out_byte = CH_BSLASH;
				CH_SLASH:  result.out_byte = CH_SLASH;
				CH_DQUOTE: begin
					if (quote_char_q == CH_DQUOTE) begin
						result.out_byte = CH_DQUOTE;
					end else begin
						result.byte_valid = 1'b0;
						result.error_code = ERR_DQUOTE;
						string_failed_d   = 1'b1;
					end
				end
				CH_SQUOTE: begin
					if (quote_char_q == CH_SQUOTE) begin
						result.out_byte = CH_SQUOTE;
					end else begin
						result.byte_valid = 1'b0;
						result.error_code = ERR_SQUOTE;
						string_failed_d   = 1'b1;
					end
				end
				default: begin
					result.byte_valid = 1'b0;
					result.error_code = ERR_UNSUPPORTED;
					string_failed_d   = 1'b1;
				end
			endcase
		end
	end

	// State is committed only when the word actually leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_char_q     <= 8'h00;
			escape_pending_q <= 1'b0;
			string_failed_q  <= 1'b0;
		end else if (fire) begin
			quote_char_q     <= quote_char_d;
			escape_pending_q <= escape_pending_d;
			string_failed_q  <= string_failed_d;
		end
	end

endmodule
